>>> design/assert_macros.svh
// Assertion macros used by the checker file.
// No dependencies; included by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, disabled while reset is asserted.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also runs through reset.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> design/mmd_pkg.sv
// Shared types and constants for the banked memory map decoder.
// No dependencies; used by the front, back and top level.
package mmd_pkg;

  // Operation codes of an input request
  localparam logic [1:0] OP_READ   = 2'd0;
  localparam logic [1:0] OP_WRITE  = 2'd1;
  localparam logic [1:0] OP_READ16 = 2'd2;
  localparam logic [1:0] OP_LOAD   = 2'd3;

  // Configuration register indexes
  localparam logic CFG_ROM_LEN    = 1'b0;
  localparam logic CFG_EXT_RAM_EN = 1'b1;

  // Access kinds produced by the front decoder
  localparam logic [3:0] K_ROM0 = 4'd0;
  localparam logic [3:0] K_ROMX = 4'd1;
  localparam logic [3:0] K_VRAM = 4'd2;
  localparam logic [3:0] K_CRAM = 4'd3;
  localparam logic [3:0] K_WRAM = 4'd4;
  localparam logic [3:0] K_OAM  = 4'd5;
  localparam logic [3:0] K_GAP  = 4'd6;
  localparam logic [3:0] K_IO   = 4'd7;
  localparam logic [3:0] K_HRAM = 4'd8;
  localparam logic [3:0] K_IE   = 4'd9;
  localparam logic [3:0] K_LOAD = 4'd10;

  localparam int RAM8K_DEPTH = 8192;
  localparam int OAM_DEPTH   = 160;
  localparam int IO_DEPTH    = 128;
  localparam int HRAM_DEPTH  = 127;

  localparam logic [7:0] OPEN_BUS = 8'hFF;
  localparam logic [6:0] BANK_MASK_ZERO = 7'd0;
  localparam logic [6:0] BANK_ONE = 7'd1;

  // One byte access passed from front to back
  typedef struct packed {
    logic [3:0]  kind;
    logic [13:0] off;
    logic        wr;
    logic [7:0]  data;
    logic [17:0] rom_index;
    logic        hi;    // second byte of a 16-bit read
    logic        last;  // this access completes a result
  } access_t;

endpackage

>>> design/mmd_fifo.sv
// Small synchronous FIFO used between front and back and for results.
// No dependencies.
module mmd_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         wr_en,
  input  logic [W-1:0]                 wr_data,
  output logic                         full,
  input  logic                         rd_en,
  output logic [W-1:0]                 rd_data,
  output logic                         empty,
  output logic [$clog2(DEPTH+1)-1:0]   count
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_wr, do_rd;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign count   = cnt_r;
  assign rd_data = mem_r[rd_ptr_r];
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

>>> design/mmd_front.sv
// Front end: takes requests, splits 16-bit reads into two byte accesses
// and classifies each address into a region. Depends on mmd_pkg.
module mmd_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  output logic                 full,
  input  logic [1:0]           in_operation,
  input  logic [15:0]          in_address,
  input  logic [7:0]           in_write_data,
  input  logic [17:0]          in_rom_index,
  input  logic                 clr_busy,
  input  logic                 q_full,
  output logic                 q_push,
  output mmd_pkg::access_t     q_entry
);

  localparam logic [15:0] OAM_BASE  = 16'hFE00;
  localparam logic [15:0] GAP_BASE  = 16'hFEA0;
  localparam logic [15:0] IO_BASE   = 16'hFF00;
  localparam logic [15:0] HRAM_BASE = 16'hFF80;
  localparam logic [15:0] IE_ADDR   = 16'hFFFF;

  logic        pend_vld_r, pend_vld_nxt;
  logic        half_r, half_nxt;
  logic [1:0]  op_r;
  logic [15:0] addr_r;
  logic [7:0]  data_r;
  logic [17:0] idx_r;

  logic [15:0] cur_addr;
  logic [3:0]  region;
  logic        is_word, issue, pend_done, accept;

  assign is_word   = (op_r == mmd_pkg::OP_READ16);
  assign issue     = pend_vld_r && !q_full;
  assign pend_done = issue && (!is_word || half_r);
  assign full      = clr_busy || (pend_vld_r && !pend_done);
  assign accept    = push && !full;
  assign cur_addr  = half_r ? addr_r + 16'd1 : addr_r;

  always_comb begin
    unique case (cur_addr[15:13]) inside
      3'b000, 3'b001: region = mmd_pkg::K_ROM0;
      3'b010, 3'b011: region = mmd_pkg::K_ROMX;
      3'b100:         region = mmd_pkg::K_VRAM;
      3'b101:         region = mmd_pkg::K_CRAM;
      3'b110:         region = mmd_pkg::K_WRAM;
      default: begin
        // top 8K: echo, sprite table, gap, IO, high RAM, IE
        if (cur_addr < OAM_BASE)       region = mmd_pkg::K_WRAM;
        else if (cur_addr < GAP_BASE)  region = mmd_pkg::K_OAM;
        else if (cur_addr < IO_BASE)   region = mmd_pkg::K_GAP;
        else if (cur_addr < HRAM_BASE) region = mmd_pkg::K_IO;
        else if (cur_addr < IE_ADDR)   region = mmd_pkg::K_HRAM;
        else                           region = mmd_pkg::K_IE;
      end
    endcase
  end

  always_comb begin
    q_push            = issue;
    q_entry.kind      = (op_r == mmd_pkg::OP_LOAD) ? mmd_pkg::K_LOAD : region;
    q_entry.off       = cur_addr[13:0];
    q_entry.wr        = (op_r == mmd_pkg::OP_WRITE);
    q_entry.data      = data_r;
    q_entry.rom_index = idx_r;
    q_entry.hi        = is_word && half_r;
    q_entry.last      = (op_r == mmd_pkg::OP_READ) || (is_word && half_r);
  end

  always_comb begin
    pend_vld_nxt = pend_vld_r;
    half_nxt     = half_r;
    if (accept) begin
      pend_vld_nxt = 1'b1;
      half_nxt     = 1'b0;
    end else if (pend_done) begin
      pend_vld_nxt = 1'b0;
      half_nxt     = 1'b0;
    end else if (issue) begin
      half_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_vld_r <= 1'b0;
      half_r     <= 1'b0;
    end else begin
      pend_vld_r <= pend_vld_nxt;
      half_r     <= half_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r   <= in_operation;
      addr_r <= in_address;
      data_r <= in_write_data;
      idx_r  <= in_rom_index;
    end
  end

endmodule

>>> design/mmd_back.sv
// Back end: owns the ROM and RAM arrays, bank and config registers, runs
// the reset clearing pass and assembles results. Depends on mmd_pkg.
module mmd_back #(
  parameter int ROM_BYTES = 262144,
  parameter int OUT_DEPTH = 4
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_wr_en,
  input  logic                             cfg_index,
  input  logic [18:0]                      cfg_wdata,
  input  logic                             q_empty,
  input  mmd_pkg::access_t                 q_entry,
  output logic                             q_pop,
  input  logic [$clog2(OUT_DEPTH+1)-1:0]   out_cnt,
  output logic                             res_push,
  output logic [15:0]                      res_data,
  output logic                             clr_busy
);

  localparam int ROM_AW = $clog2(ROM_BYTES);
  localparam logic [21:0] ROM_LIM = 22'(ROM_BYTES);
  localparam int CNT_W = $clog2(OUT_DEPTH + 1);

  // config and architectural registers
  logic [18:0] rom_len_r;
  logic        ext_en_r;
  logic [6:0]  bank_r;
  logic [7:0]  ie_r;
  logic        clr_busy_r;
  logic [12:0] clr_idx_r;

  // read stage
  logic        s2_vld_r, s2_last_r, s2_hi_r, s2_rom_ok_r;
  logic [3:0]  s2_kind_r;
  logic [7:0]  s2_ie_r, lo_r;

  logic [7:0] rom_mem  [ROM_BYTES];
  logic [7:0] vram_mem [mmd_pkg::RAM8K_DEPTH];
  logic [7:0] cram_mem [mmd_pkg::RAM8K_DEPTH];
  logic [7:0] wram_mem [mmd_pkg::RAM8K_DEPTH];
  logic [7:0] oam_mem  [mmd_pkg::OAM_DEPTH];
  logic [7:0] io_mem   [mmd_pkg::IO_DEPTH];
  logic [7:0] hram_mem [mmd_pkg::HRAM_DEPTH];
  logic [7:0] rom_q, vram_q, cram_q, wram_q, oam_q, io_q, hram_q;

  logic [CNT_W:0]    pend_res;
  logic              credit_ok, issue, do_wr, is_rd;
  logic [20:0]       rom_off, ld_wide;
  logic              rom_ok, ld_ok, rom_we;
  logic [ROM_AW-1:0] rom_addr;
  logic [6:0]        bank_wval;
  logic [7:0]        byte_sel;

  logic        vram_we, cram_we, wram_we, oam_we, io_we, hram_we;
  logic [12:0] ram_addr;
  logic [7:0]  small_addr;
  logic [7:0]  wdata;

  assign clr_busy = clr_busy_r;

  // a result may only enter the back end when the result queue has room for it
  assign pend_res  = {1'b0, out_cnt} + {{CNT_W{1'b0}}, s2_vld_r & s2_last_r};
  assign credit_ok = pend_res < (CNT_W + 1)'(OUT_DEPTH);
  assign issue     = !q_empty && !clr_busy_r && (!q_entry.last || credit_ok);
  assign q_pop     = issue;
  assign do_wr     = issue && q_entry.wr;
  assign is_rd     = !q_entry.wr && (q_entry.kind != mmd_pkg::K_LOAD);

  assign rom_off = (q_entry.kind == mmd_pkg::K_ROMX) ? {bank_r, q_entry.off}
                                                     : {7'd0, q_entry.off};
  assign rom_ok  = ({1'b0, rom_off} < ROM_LIM) && (rom_off < {2'b00, rom_len_r});
  assign ld_wide = {3'b000, q_entry.rom_index};
  assign ld_ok   = {1'b0, ld_wide} < ROM_LIM;
  assign rom_we  = issue && (q_entry.kind == mmd_pkg::K_LOAD) && ld_ok;
  assign rom_addr = rom_we ? ld_wide[ROM_AW-1:0] : rom_off[ROM_AW-1:0];

  assign bank_wval = (q_entry.data[6:0] == mmd_pkg::BANK_MASK_ZERO) ? mmd_pkg::BANK_ONE
                                                                    : q_entry.data[6:0];

  // RAM write ports: the clearing pass owns them until it finishes
  always_comb begin
    if (clr_busy_r) begin
      vram_we    = 1'b1;
      cram_we    = 1'b1;
      wram_we    = 1'b1;
      oam_we     = clr_idx_r < 13'(mmd_pkg::OAM_DEPTH);
      io_we      = clr_idx_r < 13'(mmd_pkg::IO_DEPTH);
      hram_we    = clr_idx_r < 13'(mmd_pkg::HRAM_DEPTH);
      ram_addr   = clr_idx_r;
      small_addr = clr_idx_r[7:0];
      wdata      = 8'h00;
    end else begin
      vram_we    = do_wr && (q_entry.kind == mmd_pkg::K_VRAM);
      cram_we    = do_wr && (q_entry.kind == mmd_pkg::K_CRAM) && ext_en_r;
      wram_we    = do_wr && (q_entry.kind == mmd_pkg::K_WRAM);
      oam_we     = do_wr && (q_entry.kind == mmd_pkg::K_OAM);
      io_we      = do_wr && (q_entry.kind == mmd_pkg::K_IO);
      hram_we    = do_wr && (q_entry.kind == mmd_pkg::K_HRAM);
      ram_addr   = q_entry.off[12:0];
      small_addr = q_entry.off[7:0];
      wdata      = q_entry.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rom_we) begin
      rom_mem[rom_addr] <= q_entry.data;
    end
    rom_q <= rom_mem[rom_addr];
  end

  always_ff @(posedge clk) begin
    if (vram_we) begin
      vram_mem[ram_addr] <= wdata;
    end
    vram_q <= vram_mem[ram_addr];
  end

  always_ff @(posedge clk) begin
    if (cram_we) begin
      cram_mem[ram_addr] <= wdata;
    end
    cram_q <= cram_mem[ram_addr];
  end

  always_ff @(posedge clk) begin
    if (wram_we) begin
      wram_mem[ram_addr] <= wdata;
    end
    wram_q <= wram_mem[ram_addr];
  end

  always_ff @(posedge clk) begin
    if (oam_we) begin
      oam_mem[small_addr] <= wdata;
    end
    oam_q <= oam_mem[small_addr];
  end

  always_ff @(posedge clk) begin
    if (io_we) begin
      io_mem[small_addr[6:0]] <= wdata;
    end
    io_q <= io_mem[small_addr[6:0]];
  end

  always_ff @(posedge clk) begin
    if (hram_we) begin
      hram_mem[small_addr[6:0]] <= wdata;
    end
    hram_q <= hram_mem[small_addr[6:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rom_len_r  <= '0;
      ext_en_r   <= 1'b0;
      bank_r     <= mmd_pkg::BANK_ONE;
      ie_r       <= '0;
      clr_busy_r <= 1'b1;
      clr_idx_r  <= '0;
      s2_vld_r   <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          mmd_pkg::CFG_ROM_LEN:    rom_len_r <= cfg_wdata;
          mmd_pkg::CFG_EXT_RAM_EN: ext_en_r  <= cfg_wdata[0];
          default: ;
        endcase
      end
      if (clr_busy_r) begin
        clr_idx_r <= clr_idx_r + 13'd1;
        if (clr_idx_r == 13'(mmd_pkg::RAM8K_DEPTH - 1)) begin
          clr_busy_r <= 1'b0;
        end
      end
      if (do_wr && (q_entry.kind == mmd_pkg::K_ROMX)) begin
        bank_r <= bank_wval;
      end
      if (do_wr && (q_entry.kind == mmd_pkg::K_IE)) begin
        ie_r <= q_entry.data;
      end
      s2_vld_r <= issue && is_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      s2_last_r   <= q_entry.last;
      s2_hi_r     <= q_entry.hi;
      s2_kind_r   <= q_entry.kind;
      s2_rom_ok_r <= rom_ok;
      s2_ie_r     <= ie_r;
    end
    if (s2_vld_r && !s2_last_r) begin
      lo_r <= byte_sel;
    end
  end

  always_comb begin
    unique case (s2_kind_r) inside
      mmd_pkg::K_ROM0, mmd_pkg::K_ROMX: byte_sel = s2_rom_ok_r ? rom_q : mmd_pkg::OPEN_BUS;
      mmd_pkg::K_VRAM: byte_sel = vram_q;
      mmd_pkg::K_CRAM: byte_sel = cram_q;
      mmd_pkg::K_WRAM: byte_sel = wram_q;
      mmd_pkg::K_OAM:  byte_sel = oam_q;
      mmd_pkg::K_IO:   byte_sel = io_q;
      mmd_pkg::K_HRAM: byte_sel = hram_q;
      mmd_pkg::K_IE:   byte_sel = s2_ie_r;
      default:         byte_sel = mmd_pkg::OPEN_BUS;
    endcase
  end

  assign res_push = s2_vld_r && s2_last_r;
  assign res_data = s2_hi_r ? {byte_sel, lo_r} : {8'h00, byte_sel};

endmodule

>>> design/banked_memory_map_decoder.sv
// A request is held in the front end, passes the access queue and the registered
// memory read of the back end, and its result then enters the result queue.
// Throughput: one byte request per cycle while full is low; a 16-bit read is split
// into two byte accesses through the single port of each memory and holds off the next request until both are issued.
// Reset: synchronous; afterwards full stays high while the RAMs are cleared one
// entry per cycle. ROM contents are kept.
module banked_memory_map_decoder #(
  parameter int ROM_BYTES = 262144
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  in_operation,
  input  logic [15:0] in_address,
  input  logic [7:0]  in_write_data,
  input  logic [17:0] in_rom_index,
  output logic        empty,
  input  logic        pop,
  output logic [15:0] out_read_data,
  input  logic        cfg_wr_en,
  input  logic        cfg_index,
  input  logic [18:0] cfg_wdata
);

  localparam int Q_DEPTH   = 4;
  localparam int OUT_DEPTH = 4;
  localparam int AW        = $bits(mmd_pkg::access_t);
  localparam int OCW       = $clog2(OUT_DEPTH + 1);

  mmd_pkg::access_t fe_entry, be_entry;
  logic [AW-1:0]    q_wdata, q_rdata;
  logic             q_push, q_full, q_pop, q_empty;
  logic             clr_busy;
  logic             res_push;
  logic [15:0]      res_data;
  logic [OCW-1:0]   out_cnt;

  assign q_wdata  = fe_entry;
  assign be_entry = mmd_pkg::access_t'(q_rdata);

  mmd_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .push          (push),
    .full          (full),
    .in_operation  (in_operation),
    .in_address    (in_address),
    .in_write_data (in_write_data),
    .in_rom_index  (in_rom_index),
    .clr_busy      (clr_busy),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_entry       (fe_entry)
  );

  mmd_fifo #(.W(AW), .DEPTH(Q_DEPTH)) u_access_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (q_push),
    .wr_data (q_wdata),
    .full    (q_full),
    .rd_en   (q_pop),
    .rd_data (q_rdata),
    .empty   (q_empty),
    .count   ()
  );

  mmd_back #(.ROM_BYTES(ROM_BYTES), .OUT_DEPTH(OUT_DEPTH)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .q_empty   (q_empty),
    .q_entry   (be_entry),
    .q_pop     (q_pop),
    .out_cnt   (out_cnt),
    .res_push  (res_push),
    .res_data  (res_data),
    .clr_busy  (clr_busy)
  );

  mmd_fifo #(.W(16), .DEPTH(OUT_DEPTH)) u_result_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (res_push),
    .wr_data (res_data),
    .full    (),
    .rd_en   (pop),
    .rd_data (out_read_data),
    .empty   (empty),
    .count   (out_cnt)
  );

endmodule

>>> design/mmd_checker.sv
// Port-level checks for banked_memory_map_decoder, attached by bind.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module mmd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        full,
  input logic        empty,
  input logic        pop,
  input logic [15:0] out_read_data
);

  // reset starts the RAM clearing pass, so no request may be taken right after
  `ASSERT_ALWAYS(a_full_after_reset, clk, !rst_n |=> full, "full low right after reset")
  `ASSERT_ALWAYS(a_full_clearing, clk, !rst_n ##1 rst_n |=> full, "request taken during clear")
  `ASSERT_ALWAYS(a_empty_after_reset, clk, !rst_n |=> empty, "result shown after reset")
  `ASSERT_CLK(a_result_holds, clk, rst_n, (!empty && !pop) |=> $stable(out_read_data), "result changed while waiting")

endmodule

bind banked_memory_map_decoder mmd_checker u_mmd_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .full          (full),
  .empty         (empty),
  .pop           (pop),
  .out_read_data (out_read_data)
);
